// ===== hw/rtl/event_threshold_table_top_assert.svh =====
// ---------------------------------------------------------------------------
// Event threshold table assertion macros
// Concurrent assertion wrappers used by the controller of the block.
// ---------------------------------------------------------------------------
`ifndef EVENT_THRESHOLD_TABLE_TOP_ASSERT_SVH
`define EVENT_THRESHOLD_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ETT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ETT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ETT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define ETT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/ett_pkg.sv =====
// ---------------------------------------------------------------------------
// Event threshold table package
// Shared types, codes and default sizes of the event threshold table.
// ---------------------------------------------------------------------------
package ett_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int S_TDATA_W = 168;
    localparam int S_USED_W  = 162;
    localparam int M_TDATA_W = 40;
    localparam int M_USED_W  = 35;

    localparam logic [1:0] MODE_SUPPRESS = 2'd0;
    localparam logic [1:0] MODE_LIMIT    = 2'd1;

    localparam logic [1:0] OUTCOME_MATCH  = 2'd0;
    localparam logic [1:0] OUTCOME_INSERT = 2'd1;
    localparam logic [1:0] OUTCOME_DROP   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_MISS,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic [31:0] count_limit;
        logic [31:0] window_seconds;
        logic [1:0]  mode;
        logic [31:0] rule_id;
        logic [31:0] key_hash;
    } item_t;

    typedef struct packed {
        logic [31:0] time_s;
        logic [31:0] count;
        logic [31:0] rule;
        logic [31:0] hash;
    } entry_t;

    typedef struct packed {
        logic [31:0] hit_count;
        logic [1:0]  outcome;
        logic        over_threshold;
    } result_t;

endpackage

// ===== hw/rtl/ett_mem.sv =====
// ---------------------------------------------------------------------------
// Event threshold table entry memory
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module ett_mem #(
    parameter int DEPTH = ett_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output ett_pkg::entry_t       rd_data,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  ett_pkg::entry_t       wr_data
);

    ett_pkg::entry_t mem [DEPTH];
    ett_pkg::entry_t rd_data_reg;

    // The read register holds its value between reads.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ett_ctrl.sv =====
// ---------------------------------------------------------------------------
// Event threshold table controller
// Scans the used entries; updates a match, appends a miss or drops if full.
// ---------------------------------------------------------------------------
`include "event_threshold_table_top_assert.svh"

module ett_ctrl #(
    parameter int DEPTH = ett_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  ett_pkg::item_t        item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output ett_pkg::result_t      res,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  ett_pkg::entry_t       rd_data,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output ett_pkg::entry_t       wr_data
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    ett_pkg::ctrl_state_t state_reg, state_next;
    ett_pkg::item_t       item_reg;
    ett_pkg::result_t     res_reg, res_next;
    logic [CNT_W-1:0]     used_reg;
    logic [CNT_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     hit_idx_reg;
    logic                 pend_valid_reg;

    logic                 match;
    logic                 more;
    logic                 has_room;
    logic                 timed;
    logic [31:0]          cnt_inc;
    logic [31:0]          elapsed;
    logic                 restart;
    logic [31:0]          new_cnt;
    logic [31:0]          new_time;

    // The entry in the read register is compared in the cycle after its read.
    assign match = (state_reg == ett_pkg::ST_SCAN) && pend_valid_reg &&
                   (rd_data.hash == item_reg.key_hash) &&
                   (rd_data.rule == item_reg.rule_id);
    assign more     = rd_ptr_reg < used_reg;
    assign has_room = used_reg < DEPTH_CNT;

    // Counter and window update of a matched entry.
    assign timed   = (item_reg.mode == ett_pkg::MODE_SUPPRESS) ||
                     (item_reg.mode == ett_pkg::MODE_LIMIT);
    assign cnt_inc = (rd_data.count == 32'hFFFF_FFFF) ? rd_data.count
                                                      : rd_data.count + 32'd1;
    assign elapsed = timed ? (item_reg.now_seconds - rd_data.time_s) : 32'd0;
    assign restart = elapsed > item_reg.window_seconds;
    assign new_cnt = restart ? 32'd1 : cnt_inc;
    assign new_time = (restart || (item_reg.mode == ett_pkg::MODE_SUPPRESS))
                      ? item_reg.now_seconds : rd_data.time_s;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ett_pkg::ST_IDLE: begin
                if (item_valid) begin
                    state_next = ett_pkg::ST_SCAN;
                end
            end
            ett_pkg::ST_SCAN: begin
                if (match) begin
                    state_next = ett_pkg::ST_UPDATE;
                end else if (!more && !pend_valid_reg) begin
                    state_next = ett_pkg::ST_MISS;
                end
            end
            ett_pkg::ST_UPDATE: state_next = ett_pkg::ST_DONE;
            ett_pkg::ST_MISS:   state_next = ett_pkg::ST_DONE;
            ett_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = ett_pkg::ST_IDLE;
                end
            end
            default: state_next = ett_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        item_ready = 1'b0;
        res_valid  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = rd_ptr_reg[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = used_reg[IDX_W-1:0];
        wr_data    = '{time_s: item_reg.now_seconds, count: 32'd1,
                       rule: item_reg.rule_id, hash: item_reg.key_hash};
        res_next   = res_reg;
        case (state_reg)
            ett_pkg::ST_IDLE: item_ready = 1'b1;
            ett_pkg::ST_SCAN: rd_en = !match && more;
            ett_pkg::ST_UPDATE: begin
                wr_en    = 1'b1;
                wr_addr  = hit_idx_reg[IDX_W-1:0];
                wr_data  = '{time_s: new_time, count: new_cnt,
                             rule: rd_data.rule, hash: rd_data.hash};
                res_next = '{hit_count: new_cnt, outcome: ett_pkg::OUTCOME_MATCH,
                             over_threshold: item_reg.count_limit < new_cnt};
            end
            ett_pkg::ST_MISS: begin
                wr_en = has_room;
                if (has_room) begin
                    res_next = '{hit_count: 32'd1, outcome: ett_pkg::OUTCOME_INSERT,
                                 over_threshold: 1'b0};
                end else begin
                    res_next = '{hit_count: 32'd0, outcome: ett_pkg::OUTCOME_DROP,
                                 over_threshold: 1'b0};
                end
            end
            ett_pkg::ST_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ett_pkg::ST_IDLE;
            used_reg       <= '0;
            rd_ptr_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (item_ready && item_valid) begin
                rd_ptr_reg     <= '0;
                pend_valid_reg <= 1'b0;
            end else if (state_reg == ett_pkg::ST_SCAN) begin
                pend_valid_reg <= rd_en;
                if (rd_en) begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                end
            end
            if ((state_reg == ett_pkg::ST_MISS) && has_room) begin
                used_reg <= used_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_ready && item_valid) begin
            item_reg <= item;
        end
        if (rd_en) begin
            hit_idx_reg <= rd_ptr_reg;
        end
        res_reg <= res_next;
    end

    assign res = res_reg;

    `ETT_ASSERT_NOW(a_used_bound, aclk, aresetn, 1'b1, used_reg <= DEPTH_CNT,
        "entry count exceeds the table depth")
    `ETT_ASSERT_NOW(a_read_in_use, aclk, aresetn, rd_en, rd_ptr_reg < used_reg,
        "scan read beyond the used entries")
    `ETT_ASSERT_NEXT(a_insert_grows, aclk, aresetn,
        (state_reg == ett_pkg::ST_MISS) && wr_en, used_reg == $past(used_reg) + CNT_W'(1),
        "insert did not advance the entry count")
    `ETT_ASSERT_NOW(a_write_states, aclk, aresetn, wr_en,
        (state_reg == ett_pkg::ST_UPDATE) || (state_reg == ett_pkg::ST_MISS),
        "table written outside update or insert")

endmodule

// ===== hw/rtl/event_threshold_table_top.sv =====
// ---------------------------------------------------------------------------
// Event threshold table
// Tracks per-key, per-rule event counts with time windows in a table memory.
// ---------------------------------------------------------------------------
// Usage:
// Events arrive on the s_axis channel, one event per transaction. The block
// looks the key hash and rule id up in a table of up to TABLE_DEPTH entries.
// A matching entry has its count raised (saturating) and its time window
// checked; a missing one is appended with a count of one, or the event is
// reported as dropped when the table is full. Each event yields exactly one
// result transaction on the m_axis channel, in order.
// Timing: the lookup reads one entry per cycle from a single-port-read table
// memory. An event that matches entry k (counted from zero) ends the scan at
// that entry; a miss reads all N entries in use (at most TABLE_DEPTH), and an
// empty table reads none, before the insert or the drop.
// One event is processed at a time; the next event is taken in the cycle after
// the current result has moved into the output register.
// Reset empties the table by clearing the entry count; no memory sweep is
// needed, so events are accepted as soon as reset is released.
// When the receiver stalls, the result holds in the output register, one more
// result may finish behind it and then s_axis_tready stays low.
// ---------------------------------------------------------------------------
module event_threshold_table_top #(
    parameter int TABLE_DEPTH = ett_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // key_hash[31:0], rule_id[63:32], mode[65:64], window_seconds[97:66],
    // count_limit[129:98], now_seconds[161:130], zero pad above
    input  logic [ett_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // over_threshold[0], outcome[2:1], hit_count[34:3], zero pad above
    output logic [ett_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    ett_pkg::item_t   item;
    ett_pkg::result_t res;
    ett_pkg::result_t out_reg;
    ett_pkg::entry_t  rd_data;
    ett_pkg::entry_t  wr_data;
    logic             res_valid;
    logic             res_ready;
    logic             m_valid_reg;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // The item struct is declared with the last field lowest, matching tdata.
    assign item = ett_pkg::item_t'(s_axis_tdata[ett_pkg::S_USED_W-1:0]);

    ett_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    ett_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register: a finished result moves in whenever the register is
    // empty or its current transaction completes in the same cycle.
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(ett_pkg::M_TDATA_W - ett_pkg::M_USED_W){1'b0}}, out_reg};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Event threshold table testbench
// Drives events into the table from one sender and drains results through a
// receiver that stalls at random. It tracks its own copy of the table and
// checks every result transaction in order against it, field by field. The
// run covers directed corner cases and random traffic over a pool of keys
// that is biased toward hits. It also covers a long receiver hold-off, and
// finally fills the table and drives it while full.
// ---------------------------------------------------------------------------
module tb_top;
    import ett_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 5000;

    // Mode codes that the package leaves unnamed; both count as neither mode.
    localparam logic [1:0] MODE_NEITHER = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // key_hash, rule_id, mode, window_seconds, count_limit, now_seconds, pad
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // over_threshold, outcome, hit_count, pad
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the table.
    logic [31:0] tbl_hash  [DEPTH];
    logic [31:0] tbl_rule  [DEPTH];
    logic [31:0] tbl_count [DEPTH];
    logic [31:0] tbl_stamp [DEPTH];
    int          tbl_used = 0;

    result_t     pending_results[$];
    int          fault_count = 0;
    int          n_matched = 0;
    int          n_inserted = 0;
    int          n_dropped = 0;
    int          n_flagged = 0;
    int          input_stall_cycles = 0;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [31:0] stream_now = '0;

    event_threshold_table_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one accepted event to the shadow table and returns its result.
    function automatic result_t track_event(input item_t ev);
        result_t     res;
        logic [31:0] cnt;
        logic [31:0] elapsed;
        int          slot;
        int          i;
        res  = '0;
        slot = -1;
        for (i = 0; i < tbl_used; i++) begin
            if (slot < 0 && tbl_hash[i] == ev.key_hash && tbl_rule[i] == ev.rule_id) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            cnt = tbl_count[slot];
            if (cnt != 32'hFFFF_FFFF) begin
                cnt = cnt + 32'd1;
            end
            elapsed = '0;
            if (ev.mode == MODE_SUPPRESS) begin
                elapsed = ev.now_seconds - tbl_stamp[slot];
                tbl_stamp[slot] = ev.now_seconds;
            end else if (ev.mode == MODE_LIMIT) begin
                elapsed = ev.now_seconds - tbl_stamp[slot];
            end
            // A window that has run out restarts the count.
            if (elapsed > ev.window_seconds) begin
                cnt = 32'd1;
                tbl_stamp[slot] = ev.now_seconds;
            end
            tbl_count[slot]    = cnt;
            res.over_threshold = (ev.count_limit < cnt);
            res.outcome        = OUTCOME_MATCH;
            res.hit_count      = cnt;
            n_matched++;
            if (res.over_threshold) begin
                n_flagged++;
            end
        end else if (tbl_used < DEPTH) begin
            tbl_hash[tbl_used]  = ev.key_hash;
            tbl_rule[tbl_used]  = ev.rule_id;
            tbl_count[tbl_used] = 32'd1;
            tbl_stamp[tbl_used] = ev.now_seconds;
            tbl_used++;
            res.outcome   = OUTCOME_INSERT;
            res.hit_count = 32'd1;
            n_inserted++;
        end else begin
            res.outcome = OUTCOME_DROP;
            n_dropped++;
        end
        return res;
    endfunction

    // Builds a random event. Events not drawn as fresh hit a key in the table;
    // fresh_pct sets the share of keys not taken from the table.
    function automatic item_t build_event(input int fresh_pct);
        item_t ev;
        int    idx;
        int    pick;
        if (tbl_used == 0 || $urandom_range(99) < fresh_pct) begin
            idx = (tbl_used == 0) ? 0 : $urandom_range(tbl_used - 1);
            ev.key_hash = $urandom;
            ev.rule_id  = $urandom;
            if (tbl_used != 0) begin
                // Near misses: one flipped bit, or a shared hash with another rule.
                case ($urandom_range(3))
                    0: begin
                        ev.key_hash = tbl_hash[idx] ^ (32'd1 << $urandom_range(31));
                        ev.rule_id  = tbl_rule[idx];
                    end
                    1: begin
                        ev.key_hash = tbl_hash[idx];
                        ev.rule_id  = tbl_rule[idx] ^ (32'd1 << $urandom_range(31));
                    end
                    2: ev.key_hash = tbl_hash[idx];
                    default: ;
                endcase
            end
        end else begin
            idx = $urandom_range(tbl_used - 1);
            ev.key_hash = tbl_hash[idx];
            ev.rule_id  = tbl_rule[idx];
        end

        pick = $urandom_range(9);
        if (pick < 4) begin
            ev.mode = MODE_SUPPRESS;
        end else if (pick < 8) begin
            ev.mode = MODE_LIMIT;
        end else if (pick == 8) begin
            ev.mode = MODE_NEITHER;
        end else begin
            ev.mode = MODE_SPARE;
        end

        case ($urandom_range(9))
            0, 1, 2, 3, 4: ev.window_seconds = $urandom_range(16);
            5, 6:          ev.window_seconds = $urandom;
            7:             ev.window_seconds = '0;
            8:             ev.window_seconds = '1;
            default:       ev.window_seconds = 32'hFFFF_FFFF - $urandom_range(16);
        endcase

        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: ev.count_limit = $urandom_range(8);
            7:                   ev.count_limit = $urandom;
            8:                   ev.count_limit = '0;
            default:             ev.count_limit = '1;
        endcase

        // Time mostly creeps forward, with rare jumps and steps back.
        pick = $urandom_range(99);
        if (pick < 4) begin
            stream_now = $urandom;
        end else if (pick < 7) begin
            stream_now = stream_now - $urandom_range(1, 20);
        end else begin
            stream_now = stream_now + $urandom_range(0, 6);
        end
        ev.now_seconds = stream_now;
        return ev;
    endfunction

    // Offers one event and waits until the block takes it. The valid line is
    // only dropped during idle gaps, so back-to-back events keep it high.
    task automatic send_event(input item_t ev);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - S_USED_W){1'b0}}, ev};
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(track_event(ev));
    endtask

    task automatic send_fields(input logic [31:0] hash, input logic [31:0] rule,
                               input logic [1:0] mode, input logic [31:0] window,
                               input logic [31:0] limit, input logic [31:0] now_s);
        item_t ev;
        ev.key_hash       = hash;
        ev.rule_id        = rule;
        ev.mode           = mode;
        ev.window_seconds = window;
        ev.count_limit    = limit;
        ev.now_seconds    = now_s;
        send_event(ev);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            fault_count++;
            if (fault_count <= 40) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        end
    endtask

    // Result checker: every result transaction is matched to the oldest
    // prediction still waiting.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = result_t'(m_axis_tdata[M_USED_W-1:0]);
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 40) begin
                    $display("%0t ns: unexpected result, expected none, actual %0h",
                             $time, got);
                end
            end else begin
                want = pending_results.pop_front();
                compare_field("over_threshold", 32'(want.over_threshold),
                              32'(got.over_threshold));
                compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
                compare_field("hit_count", want.hit_count, got.hit_count);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run once no transaction has moved for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (aresetn && s_axis_tvalid && !s_axis_tready) begin
                input_stall_cycles++;
            end
        end
        $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Corner cases: field extremes, every mode, window edges and time wrap.
    task automatic test_directed_cases();
        send_idle_pct = 37;
        recv_idle_pct = 63;
        send_fields(32'h0, 32'h0, MODE_SUPPRESS, 32'd10, 32'd0, 32'd0);
        send_fields('1, '1, MODE_LIMIT, '1, '1, '1);
        send_fields(32'h0, '1, MODE_SUPPRESS, '1, 32'd0, 32'hFFFF_FFF0);
        send_fields('1, 32'h0, MODE_NEITHER, 32'd0, 32'd0, 32'h8000_0000);
        // Elapsed below, at and above the window in suppress mode.
        send_fields(32'h0, 32'h0, MODE_SUPPRESS, 32'd10, 32'd0, 32'd5);
        send_fields(32'h0, 32'h0, MODE_SUPPRESS, 32'd10, 32'd2, 32'd15);
        send_fields(32'h0, 32'h0, MODE_SUPPRESS, 32'd10, 32'd3, 32'd26);
        // Limit mode across the wrap of the seconds counter.
        send_fields('1, '1, MODE_LIMIT, 32'd100, 32'd1, 32'd50);
        send_fields('1, '1, MODE_LIMIT, 32'd100, 32'd1, 32'd140);
        send_fields('1, '1, MODE_NEITHER, 32'd0, 32'd0, 32'd7);
        send_fields('1, '1, MODE_SPARE, 32'd0, '1, 32'd0);
        // Widest window never restarts; a zero window restarts on any gap.
        send_fields(32'h0, '1, MODE_SUPPRESS, '1, 32'd0, 32'h0000_0010);
        send_fields(32'h0, '1, MODE_LIMIT, 32'd0, 32'd0, 32'h0000_0010);
        send_fields(32'h0, '1, MODE_LIMIT, 32'd0, 32'd0, 32'h0000_0011);
        send_fields('1, 32'h0, MODE_SUPPRESS, 32'h7FFF_FFFF, 32'h5555_5555, 32'h0);
        send_fields('1, 32'h0, MODE_LIMIT, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
        send_fields(32'hA5A5_5A5A, 32'h5A5A_A5A5, MODE_SPARE, 32'h5555_5555,
                    32'h5555_5555, 32'hAAAA_AAAA);
        send_fields(32'h5A5A_A5A5, 32'hA5A5_5A5A, MODE_SUPPRESS, 32'hAAAA_AAAA,
                    32'h0, 32'h5555_5555);
        // Count climbing one step at a time, each step just past its limit.
        send_fields(32'h0, 32'h0, MODE_SUPPRESS, 32'd10, 32'd1, 32'd26);
        send_fields(32'h0, 32'h0, MODE_SUPPRESS, 32'd10, 32'd2, 32'd27);
        send_fields(32'h0, 32'h0, MODE_SUPPRESS, 32'd10, 32'd3, 32'd28);
    endtask

    // Random traffic over a small table, most events hitting known keys.
    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        int n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stream_now    = $urandom;
        for (n = 0; n < count; n++) begin
            send_event(build_event((tbl_used < 48) ? 12 : 1));
        end
    endtask

    // The receiver holds off while events keep coming, so the block backs up.
    task automatic test_output_backpressure();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        for (n = 0; n < 24; n++) begin
            send_event(build_event(5));
        end
    endtask

    // Fill every entry, then keep hitting and missing on the full table.
    task automatic test_table_full();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (tbl_used < DEPTH) begin
            send_event(build_event(100));
        end
        for (n = 0; n < 60; n++) begin
            send_event(build_event(40));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_traffic(400, 37, 63);
        test_random_traffic(400, 63, 37);
        test_random_traffic(400, 0, 0);
        test_output_backpressure();
        test_table_full();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        // A full scan and the output stage; anything arriving here is extra.
        repeat (DEPTH + 16) @(posedge aclk);

        $display("Covered %0d events: %0d matched, %0d inserted, %0d dropped, %0d flagged.",
                 n_matched + n_inserted + n_dropped, n_matched, n_inserted, n_dropped,
                 n_flagged);
        $display("Table filled to %0d of %0d entries; input stalled %0d cycles.",
                 tbl_used, DEPTH, input_stall_cycles);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
